// ===== src/sha256_block_engine_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 block engine assertion macros
// Concurrent check helpers, clocked on clk_i and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_BLOCK_ENGINE_DEFINES_SVH
`define SHA256_BLOCK_ENGINE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA_ASSERT_IMP(lbl, ante, cons, msg)
`define SHA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Request types, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] word_arr_t;

  // input request: one message word and its flags
  typedef struct packed {
    logic [31:0] message_word;
    logic        new_message;
    logic        final_block;
  } in_req_t;

  // output request: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_req_t;

  // schedule window control
  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] word;
  } sched_ctrl_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash, index 0 is word a
  localparam word_arr_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;

  function automatic word_t rotr32(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== src/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word sliding window: shifts in message words, then expands W[t+16].
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                    clk_i,
  input  sha256_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]             wt_o
);
  import sha256_pkg::*;

  word_t w_q [BLOCK_WORDS];
  word_t w_d [BLOCK_WORDS];
  word_t w_new;

  // next schedule word from the window taps
  assign w_new = w_q[0] + small_sig0(w_q[1]) + w_q[9] + small_sig1(w_q[14]);
  assign wt_o  = w_q[0];

  // window shift: message word while loading, expanded word while running
  always_comb begin
    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
      w_d[i] = w_q[i + 1];
    end
    w_d[BLOCK_WORDS - 1] = ctrl_i.load ? ctrl_i.word : w_new;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load || ctrl_i.step) begin
      w_q <= w_d;
    end
  end

endmodule

// ===== src/sha256_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round on the working variables, shared over all 64 rounds.
// ----------------------------------------------------------------------------
module sha256_round (
  input  sha256_pkg::word_arr_t v_i,
  input  logic [31:0]           wt_i,
  input  logic [31:0]           kt_i,
  output sha256_pkg::word_arr_t v_o
);
  import sha256_pkg::*;

  word_t t_one;
  word_t t_two;

  assign t_one = v_i[7] + big_sig1(v_i[4]) + choose(v_i[4], v_i[5], v_i[6]) + kt_i + wt_i;
  assign t_two = big_sig0(v_i[0]) + major(v_i[0], v_i[1], v_i[2]);

  // rotate the working variables
  always_comb begin
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t_one;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t_one + t_two;
  end

endmodule

// ===== src/sha256_block_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block engine
// Gathers sixteen message words, compresses the block, emits the digest.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while idle; the sixteenth starts the rounds on the
// one shared round unit, then an add state folds them into the chaining value.
// A final block then emits eight digest words, one per cycle while not stalled.
// Reset loads the initial hash, clears the working variables and counters;
// the schedule window is not reset.
module sha256_block_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sha256_pkg::in_req_t   in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sha256_pkg::out_req_t  out_req_o
);
  import sha256_pkg::*;

  `include "sha256_block_engine_defines.svh"

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [3:0] LAST_WORD  = 4'(BLOCK_WORDS - 1);
  localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
  localparam logic [2:0] LAST_DIG   = 3'd7;

  logic [1:0]  state_q, state_d;
  logic [3:0]  word_cnt_q, word_cnt_d;
  logic [5:0]  round_q, round_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        final_q, final_d;
  word_arr_t   chain_q, chain_d;
  word_arr_t   v_q, v_d;
  word_arr_t   v_next;
  word_t       wt;
  logic        in_accept;
  sched_ctrl_t sched_ctrl;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign sched_ctrl.load = in_accept;
  assign sched_ctrl.step = (state_q == ST_ROUND);
  assign sched_ctrl.word = in_req_i.message_word;

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .wt_o   (wt)
  );

  sha256_round u_round (
    .v_i  (v_q),
    .wt_i (wt),
    .kt_i (ROUND_K[round_q]),
    .v_o  (v_next)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    word_cnt_d = word_cnt_q;
    round_d    = round_q;
    out_idx_d  = out_idx_q;
    final_d    = final_q;
    chain_d    = chain_q;
    v_d        = v_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (word_cnt_q == 4'd0 && in_req_i.new_message) begin
            chain_d = INIT_HASH;
          end
          word_cnt_d = word_cnt_q + 4'd1;
          if (word_cnt_q == LAST_WORD) begin
            final_d = in_req_i.final_block;
            v_d     = chain_d;
            round_d = '0;
            state_d = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        v_d     = v_next;
        round_d = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + v_q[i];
        end
        out_idx_d = '0;
        state_d   = final_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          out_idx_d = out_idx_q + 3'd1;
          if (out_idx_q == LAST_DIG) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      word_cnt_q <= '0;
      round_q    <= '0;
      out_idx_q  <= '0;
      final_q    <= 1'b0;
      chain_q    <= INIT_HASH;
      v_q        <= '0;
    end else begin
      state_q    <= state_d;
      word_cnt_q <= word_cnt_d;
      round_q    <= round_d;
      out_idx_q  <= out_idx_d;
      final_q    <= final_d;
      chain_q    <= chain_d;
      v_q        <= v_d;
    end
  end

  // digest output, held while stalled
  assign out_valid_o           = (state_q == ST_EMIT);
  assign out_req_o.digest_word = chain_q[out_idx_q];
  assign out_req_o.digest_last = (out_idx_q == LAST_DIG);

  // checks
  `SHA_ASSERT_NXT(a_block_start, in_accept && word_cnt_q == LAST_WORD,
    state_q == ST_ROUND && round_q == 6'd0, "block did not start rounds")
  `SHA_ASSERT_NXT(a_round_end, state_q == ST_ROUND && round_q == LAST_ROUND,
    state_q == ST_ADD, "rounds did not end in add")
  `SHA_ASSERT_NXT(a_emit_end, out_valid_o && !out_stall_i && out_req_o.digest_last,
    state_q == ST_IDLE && !out_valid_o, "digest ran past last word")
  `SHA_ASSERT_NXT(a_no_emit, state_q == ST_ADD && !final_q,
    state_q == ST_IDLE, "digest emitted for non-final block")

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 block engine testbench
// A queue-fed driver sends message words while a clocked monitor
// compares each digest word with a built-in SHA-256 predictor. Both sides
// idle at random. The receiver holds off once for a long stretch, and the
// sender pauses twice until every digest word has come back.
// ----------------------------------------------------------------------------
module tb_top;

  import sha256_pkg::in_req_t;
  import sha256_pkg::out_req_t;

  localparam int ITEM_TARGET = 410;
  localparam int MIN_DIGESTS = 10;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 120;
  localparam int MAX_REPORTS = 10;

  // SHA-256 round constants
  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value, word a first
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // one queued request plus a flag to wait for all digests first
  typedef struct {
    in_req_t req;
    bit      wait_drain;
  } word_item_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid    = 1'b0;
  in_req_t  in_req      = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall   = 1'b0;
  out_req_t out_req;

  word_item_t  word_q [$];
  out_req_t    digest_q [$];

  // predictor state
  logic [31:0] chain [8];
  logic [31:0] block_buf [16];
  int          word_idx = 0;

  bit in_taken        = 1'b0;
  int idle_cycles     = 0;
  int words_taken     = 0;
  int digest_words    = 0;
  int fail_count      = 0;
  int send_gap        = 0;
  int send_burst      = 0;
  int recv_left       = 0;
  int recv_burst      = 0;
  bit long_hold_done  = 1'b0;

  sha256_block_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // compress block_buf into chain
  function automatic void hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int r;
    for (r = 0; r < 16; r++) w[r] = block_buf[r];
    for (r = 16; r < 64; r++) begin
      s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    for (r = 0; r < 8; r++) v[r] = chain[r];
    for (r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (r = 0; r < 8; r++) chain[r] = chain[r] + v[r];
  endfunction

  // take one accepted message word; queue the digest after a final block
  function automatic void absorb_word(in_req_t r);
    out_req_t d;
    int i;
    if (word_idx == 0 && r.new_message) begin
      for (i = 0; i < 8; i++) chain[i] = IV[i];
    end
    block_buf[word_idx] = r.message_word;
    if (word_idx < 15) begin
      word_idx++;
    end else begin
      word_idx = 0;
      hash_block();
      if (r.final_block) begin
        for (i = 0; i < 8; i++) begin
          d.digest_word = chain[i];
          d.digest_last = (i == 7);
          digest_q.push_back(d);
        end
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  // idle length: mostly short, a few long, with idle-free stretches
  function automatic int pick_idle(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_word(logic [31:0] w, bit nm, bit fb, bit drain);
    word_item_t it;
    it.req.message_word = w;
    it.req.new_message  = nm;
    it.req.final_block  = fb;
    it.wait_drain       = drain;
    word_q.push_back(it);
  endfunction

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // driver: next request goes out on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive
    logic    nxt_valid;
    in_req_t nxt_req;
    nxt_valid = in_valid;
    nxt_req   = in_req;
    if (rst_ni) begin
      if (in_valid && in_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() > 0 &&
                     !(word_q[0].wait_drain && digest_q.size() > 0)) begin
          nxt_req   = word_q[0].req;
          nxt_valid = 1'b1;
          void'(word_q.pop_front());
          send_gap  = pick_idle(send_burst);
        end
      end
    end
    in_valid <= nxt_valid;
    in_req   <= nxt_req;
  end

  // --------------------------------------------------------------------------
  // receiver stall, with one long hold once traffic is flowing
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : receive
    if (rst_ni) begin
      if (!long_hold_done && out_valid && words_taken >= 64) begin
        long_hold_done = 1'b1;
        recv_left      = LONG_HOLD;
      end else if (recv_left == 0) begin
        recv_left = pick_idle(recv_burst);
      end
    end
    out_stall <= (recv_left > 0);
    if (recv_left > 0) recv_left--;
  end

  // --------------------------------------------------------------------------
  // monitor: sample both handshakes on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    out_req_t want;
    in_taken = 1'b0;
    if (rst_ni) begin
      idle_cycles++;
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        absorb_word(in_req);
        words_taken++;
        idle_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (digest_q.size() == 0) begin
          log_failure($sformatf("unexpected digest word %h last %b",
                                out_req.digest_word, out_req.digest_last));
        end else begin
          want = digest_q.pop_front();
          if (out_req.digest_word !== want.digest_word ||
              out_req.digest_last !== want.digest_last)
            log_failure($sformatf("digest word %0d: expected %h last %b, got %h last %b",
                                  digest_words, want.digest_word, want.digest_last,
                                  out_req.digest_word, out_req.digest_last));
        end
        digest_words++;
      end
    end
  end

  // watchdog on cycles with no traffic at all
  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("** sha256_block_engine: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          i, b, w, nblocks, msg, finals;
    logic [31:0] dw;
    bit          fresh, broken, nm, fb;

    for (i = 0; i < 8; i++) chain[i] = IV[i];

    // first block after reset: no reload flag, new-message flag on word 5
    // and an early final flag on word 3, both to be ignored
    for (i = 0; i < 16; i++) begin
      case (i)
        0:       dw = 32'h0000_0000;
        1:       dw = 32'hffff_ffff;
        2:       dw = 32'h8000_0000;
        3:       dw = 32'h0000_0001;
        default: dw = i[0] ? (32'haaaa_aaaa ^ i) : (32'h5555_5555 + i);
      endcase
      queue_word(dw, i == 5, i == 3 || i == 15, 1'b0);
    end
    // second block goes on from the digest just emitted, no reload
    for (i = 0; i < 16; i++) queue_word(i[0] ? 32'hffff_ffff : 32'h0, 1'b0, i == 15, 1'b0);

    // random messages of one to three blocks, some of them malformed
    msg    = 0;
    finals = 2;
    while (word_q.size() < ITEM_TARGET || finals < MIN_DIGESTS) begin
      i       = $urandom_range(0, 9);
      nblocks = (i < 6) ? 1 : (i < 9) ? 2 : 3;
      fresh   = ($urandom_range(0, 9) != 0);
      broken  = ($urandom_range(0, 9) == 0);
      for (b = 0; b < nblocks; b++) begin
        for (w = 0; w < 16; w++) begin
          nm = (b == 0 && w == 0) ? fresh : ($urandom_range(0, 9) == 0);
          if (w == 15)
            fb = (b == nblocks - 1) ? !broken : ($urandom_range(0, 7) == 0);
          else
            fb = ($urandom_range(0, 9) == 0);
          if (w == 15 && fb) finals++;
          queue_word(pick_word(), nm, fb, b == 0 && w == 0 && (msg == 8 || msg == 13));
        end
      end
      msg++;
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests sent and every digest word back
    while (word_q.size() > 0 || in_valid || digest_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** sha256_block_engine: PASSED **");
    end else begin
      $display("** sha256_block_engine: FAILED **");
    end
    $finish;
  end

endmodule
